// ===== sv/hsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types and constants of the histogram smooth/compare engine.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int MAX_BINS_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [8:0]  BINS_RESET = 9'd256;
  localparam logic [39:0] OUT_MAX    = 40'hFF_FFFF_FFFF;
  localparam int          ONE_COUNT  = 256;
  localparam int          MIN_BINS   = 3;

  // last divider step for a bin term (33 quotient bits) and the final
  // reciprocal (49 quotient bits)
  localparam int TERM_LAST  = 32;
  localparam int FINAL_LAST = 48;
  localparam int QUO_W      = 49;

  typedef enum logic [2:0] {
    OP_INC    = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_SMOOTH = 3'd2,
    OP_LOAD   = 3'd3,
    OP_VOLUME = 3'd4,
    OP_PEAK   = 3'd5,
    OP_CMP    = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BIN   = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_SAT   = 2'd3
  } stat_t;

  localparam logic REG_BINS = 1'b0;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_INC_RD, S_INC_WR, S_CLR,
    S_SM0, S_SM1, S_SM2, S_SM_RD, S_SM_WR,
    S_SUM_RD, S_SUM_ACC, S_CMP_RD, S_CMP_CHK,
    S_MUL, S_TERM, S_DIV, S_FSET, S_FIN
  } state_t;

endpackage

// ===== sv/histogram_smooth_compare_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_smooth_compare_top
// Histogram engine with a reference store: increment, clear, 1-2-1 smooth,
// reference load, volume and peak queries, chi-square style compare.
// ----------------------------------------------------------------------------
// One transaction in, one result out, one operation at a time. After reset
// a clearing pass over all MAX_BINS entries zeroes both stores before the
// first transaction is taken. Load, peak and unused codes go straight to
// the result; increment updates one bin; clear, smooth and volume sweep the
// active bins; compare runs the volume sweep (an empty histogram or
// reference ends there), skips each empty bin, takes each nonzero bin
// through the shift-add multiplier and restoring divider, and ends with
// the final reciprocal (skipped when the term sum is zero). Each result
// passes through the finish state to the output register, later while an
// earlier stalled result still sits there; the register holds it while the
// next transaction is accepted. Both stores are single-write memories with
// a registered read; the multiply and divide share one step counter.
module histogram_smooth_compare_top #(
  parameter int MAX_BINS    = hsc_pkg::MAX_BINS_DEF,
  parameter int COUNT_WIDTH = hsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  bin,
  input  logic [31:0] ref_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [39:0] result_value,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW    = COUNT_WIDTH;
  localparam int AW    = $clog2(MAX_BINS);
  localparam int NW    = $clog2(MAX_BINS + 1);
  localparam int VW    = CW + AW;
  localparam int PW    = VW + CW;
  localparam int DW    = PW + 2;
  localparam int SW    = 33 + AW;
  localparam int XW    = (VW > 40) ? VW : 40;
  localparam int STEPS = (CW > hsc_pkg::QUO_W) ? CW : hsc_pkg::QUO_W;
  localparam int KW    = $clog2(STEPS);
  localparam int QW    = hsc_pkg::QUO_W;

  // configuration
  logic [8:0] bins_in_use;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == hsc_pkg::REG_BINS);
  assign prdata = (paddr[2] == hsc_pkg::REG_BINS) ? 32'(bins_in_use) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= hsc_pkg::BINS_RESET;
    end else if (cfg_wr) begin
      bins_in_use <= pwdata[8:0];
    end
  end

  logic [NW-1:0] n_act;
  always_comb begin
    if (32'(bins_in_use) < 32'(hsc_pkg::MIN_BINS)) begin
      n_act = NW'(hsc_pkg::MIN_BINS);
    end else if (32'(bins_in_use) > 32'(MAX_BINS)) begin
      n_act = NW'(MAX_BINS);
    end else begin
      n_act = NW'(bins_in_use);
    end
  end

  // stores
  logic [CW-1:0] bin_mem [MAX_BINS];
  logic [CW-1:0] ref_mem [MAX_BINS];
  logic [CW-1:0] bin_rd, ref_rd, bin_wd, ref_wd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          bin_we, ref_we;

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[wr_addr] <= bin_wd;
    end
    if (ref_we) begin
      ref_mem[wr_addr] <= ref_wd;
    end
    bin_rd <= bin_mem[rd_addr];
    ref_rd <= ref_mem[rd_addr];
  end

  // control and datapath registers
  hsc_pkg::state_t state, state_next;
  hsc_pkg::op_t    op_reg, op_next;
  logic [7:0]      bin_reg, bin_next;
  logic [NW-1:0]   idx, idx_next;
  logic [CW-1:0]   peak, peak_next;
  logic [CW-1:0]   prev, prev_next, cur, cur_next;
  logic [VW-1:0]   vr, vr_next, vs, vs_next;
  logic [CW-1:0]   a_sh, a_sh_next, b_sh, b_sh_next;
  logic [PW-1:0]   p, p_next, q, q_next;
  logic [DW-1:0]   rem, rem_next, dvs, dvs_next;
  logic [QW-1:0]   quo, quo_next;
  logic [KW-1:0]   step, step_next;
  logic [SW-1:0]   sum, sum_next;
  logic            fin_div, fin_div_next;
  logic [39:0]     res, res_next;
  hsc_pkg::stat_t  st, st_next;
  logic            out_valid_next;
  logic [39:0]     result_next;
  logic [1:0]      status_next;

  // scratch
  logic          in_ok, last;
  logic [CW:0]   inc_sum;
  logic [CW-1:0] inc_val;
  logic [CW+1:0] filt;
  logic [XW-1:0] vr_x;
  logic [DW-1:0] div_r;
  logic          div_ge;

  assign in_stall = (state != hsc_pkg::S_IDLE);
  assign in_ok    = 32'(bin) < 32'(n_act);
  assign last     = (idx == n_act - NW'(1));
  assign inc_sum  = {1'b0, bin_rd} + (CW + 1)'(hsc_pkg::ONE_COUNT);
  assign inc_val  = inc_sum[CW] ? {CW{1'b1}} : inc_sum[CW-1:0];
  assign filt     = (CW + 2)'(prev) + {1'b0, cur, 1'b0} + (CW + 2)'(bin_rd);
  assign div_r    = (step == KW'(0)) ? rem : {rem[DW-2:0], 1'b0};
  assign div_ge   = (div_r >= dvs);

  always_comb begin
    state_next     = state;
    op_next        = op_reg;
    bin_next       = bin_reg;
    idx_next       = idx;
    peak_next      = peak;
    prev_next      = prev;
    cur_next       = cur;
    vr_next        = vr;
    vs_next        = vs;
    a_sh_next      = a_sh;
    b_sh_next      = b_sh;
    p_next         = p;
    q_next         = q;
    rem_next       = rem;
    dvs_next       = dvs;
    quo_next       = quo;
    step_next      = step;
    sum_next       = sum;
    fin_div_next   = fin_div;
    res_next       = res;
    st_next        = st;
    vr_x           = '0;
    rd_addr        = idx[AW-1:0];
    wr_addr        = idx[AW-1:0];
    bin_we         = 1'b0;
    ref_we         = 1'b0;
    bin_wd         = '0;
    ref_wd         = '0;
    out_valid_next = out_valid && out_stall;
    result_next    = result_value;
    status_next    = status;

    case (state)
      hsc_pkg::S_INIT: begin
        bin_we = 1'b1;
        ref_we = 1'b1;
        if (idx == NW'(MAX_BINS - 1)) begin
          state_next = hsc_pkg::S_IDLE;
        end else begin
          idx_next = idx + NW'(1);
        end
      end
      hsc_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next  = hsc_pkg::op_t'(operation);
          bin_next = bin;
          idx_next = '0;
          vr_next  = '0;
          vs_next  = '0;
          sum_next = '0;
          res_next = '0;
          st_next  = hsc_pkg::STAT_OK;
          case (hsc_pkg::op_t'(operation))
            hsc_pkg::OP_INC: begin
              if (in_ok) begin
                state_next = hsc_pkg::S_INC_RD;
              end else begin
                st_next    = hsc_pkg::STAT_BIN;
                state_next = hsc_pkg::S_FIN;
              end
            end
            hsc_pkg::OP_CLEAR:  state_next = hsc_pkg::S_CLR;
            hsc_pkg::OP_SMOOTH: state_next = hsc_pkg::S_SM0;
            hsc_pkg::OP_LOAD: begin
              if (in_ok) begin
                ref_we  = 1'b1;
                wr_addr = AW'(bin);
                ref_wd  = CW'(ref_value);
              end else begin
                st_next = hsc_pkg::STAT_BIN;
              end
              state_next = hsc_pkg::S_FIN;
            end
            hsc_pkg::OP_VOLUME, hsc_pkg::OP_CMP: state_next = hsc_pkg::S_SUM_RD;
            hsc_pkg::OP_PEAK: begin
              res_next   = 40'(peak);
              state_next = hsc_pkg::S_FIN;
            end
            default: state_next = hsc_pkg::S_FIN;
          endcase
        end
      end
      hsc_pkg::S_INC_RD: begin
        rd_addr    = AW'(bin_reg);
        state_next = hsc_pkg::S_INC_WR;
      end
      hsc_pkg::S_INC_WR: begin
        bin_we  = 1'b1;
        wr_addr = AW'(bin_reg);
        bin_wd  = inc_val;
        if (inc_val > peak) begin
          peak_next = inc_val;
        end
        state_next = hsc_pkg::S_FIN;
      end
      hsc_pkg::S_CLR: begin
        bin_we = 1'b1;
        if (last) begin
          peak_next  = '0;
          state_next = hsc_pkg::S_FIN;
        end else begin
          idx_next = idx + NW'(1);
        end
      end
      hsc_pkg::S_SM0: begin
        rd_addr    = AW'(1);
        state_next = hsc_pkg::S_SM1;
      end
      hsc_pkg::S_SM1: begin
        bin_we     = 1'b1;
        wr_addr    = '0;
        bin_wd     = bin_rd;
        prev_next  = bin_rd;
        cur_next   = bin_rd;
        rd_addr    = AW'(n_act - NW'(2));
        state_next = hsc_pkg::S_SM2;
      end
      hsc_pkg::S_SM2: begin
        bin_we     = 1'b1;
        wr_addr    = AW'(n_act - NW'(1));
        bin_wd     = bin_rd;
        idx_next   = NW'(1);
        state_next = hsc_pkg::S_SM_RD;
      end
      hsc_pkg::S_SM_RD: begin
        rd_addr    = AW'(idx + NW'(1));
        state_next = hsc_pkg::S_SM_WR;
      end
      hsc_pkg::S_SM_WR: begin
        bin_we    = 1'b1;
        bin_wd    = filt[CW+1:2];
        prev_next = cur;
        cur_next  = bin_rd;
        if (idx + NW'(2) == n_act) begin
          state_next = hsc_pkg::S_FIN;
        end else begin
          idx_next   = idx + NW'(1);
          state_next = hsc_pkg::S_SM_RD;
        end
      end
      hsc_pkg::S_SUM_RD: state_next = hsc_pkg::S_SUM_ACC;
      hsc_pkg::S_SUM_ACC: begin
        vr_next = vr + VW'(bin_rd);
        vs_next = vs + VW'(ref_rd);
        if (!last) begin
          idx_next   = idx + NW'(1);
          state_next = hsc_pkg::S_SUM_RD;
        end else if (op_reg == hsc_pkg::OP_VOLUME) begin
          vr_x       = XW'(vr_next);
          res_next   = (vr_x > XW'(hsc_pkg::OUT_MAX)) ? hsc_pkg::OUT_MAX : 40'(vr_x);
          state_next = hsc_pkg::S_FIN;
        end else if (vr_next == '0 || vs_next == '0) begin
          st_next    = hsc_pkg::STAT_EMPTY;
          state_next = hsc_pkg::S_FIN;
        end else begin
          idx_next   = '0;
          state_next = hsc_pkg::S_CMP_RD;
        end
      end
      hsc_pkg::S_CMP_RD: state_next = hsc_pkg::S_CMP_CHK;
      hsc_pkg::S_CMP_CHK: begin
        a_sh_next = bin_rd;
        b_sh_next = ref_rd;
        p_next    = '0;
        q_next    = '0;
        step_next = '0;
        if (bin_rd != '0 || ref_rd != '0) begin
          state_next = hsc_pkg::S_MUL;
        end else if (last) begin
          state_next = hsc_pkg::S_FSET;
        end else begin
          idx_next   = idx + NW'(1);
          state_next = hsc_pkg::S_CMP_RD;
        end
      end
      hsc_pkg::S_MUL: begin
        // MSB-first shift-add: p = S*a, q = R*b
        p_next    = {p[PW-2:0], 1'b0} + (a_sh[CW-1] ? PW'(vs) : PW'(0));
        q_next    = {q[PW-2:0], 1'b0} + (b_sh[CW-1] ? PW'(vr) : PW'(0));
        a_sh_next = {a_sh[CW-2:0], 1'b0};
        b_sh_next = {b_sh[CW-2:0], 1'b0};
        step_next = step + KW'(1);
        if (step == KW'(CW - 1)) begin
          state_next = hsc_pkg::S_TERM;
        end
      end
      hsc_pkg::S_TERM: begin
        rem_next     = (p >= q) ? DW'(p - q) : DW'(q - p);
        dvs_next     = DW'(p) + DW'(q);
        quo_next     = '0;
        step_next    = '0;
        fin_div_next = 1'b0;
        state_next   = hsc_pkg::S_DIV;
      end
      hsc_pkg::S_DIV: begin
        rem_next  = div_ge ? (div_r - dvs) : div_r;
        quo_next  = {quo[QW-2:0], div_ge};
        step_next = step + KW'(1);
        if (!fin_div && step == KW'(hsc_pkg::TERM_LAST)) begin
          sum_next = sum + SW'(quo_next[32:0]);
          if (last) begin
            state_next = hsc_pkg::S_FSET;
          end else begin
            idx_next   = idx + NW'(1);
            state_next = hsc_pkg::S_CMP_RD;
          end
        end else if (fin_div && step == KW'(hsc_pkg::FINAL_LAST)) begin
          if (quo_next > QW'(hsc_pkg::OUT_MAX)) begin
            res_next = hsc_pkg::OUT_MAX;
            st_next  = hsc_pkg::STAT_SAT;
          end else begin
            res_next = 40'(quo_next);
          end
          state_next = hsc_pkg::S_FIN;
        end
      end
      hsc_pkg::S_FSET: begin
        if (sum == '0) begin
          res_next   = hsc_pkg::OUT_MAX;
          st_next    = hsc_pkg::STAT_SAT;
          state_next = hsc_pkg::S_FIN;
        end else begin
          // 2^48 / sum: dividend MSB enters as the initial remainder
          rem_next     = DW'(1);
          dvs_next     = DW'(sum);
          quo_next     = '0;
          step_next    = '0;
          fin_div_next = 1'b1;
          state_next   = hsc_pkg::S_DIV;
        end
      end
      hsc_pkg::S_FIN: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          result_next    = res;
          status_next    = st;
          state_next     = hsc_pkg::S_IDLE;
        end
      end
      default: state_next = hsc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hsc_pkg::S_INIT;
      idx       <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      peak      <= peak_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_reg       <= op_next;
    bin_reg      <= bin_next;
    prev         <= prev_next;
    cur          <= cur_next;
    vr           <= vr_next;
    vs           <= vs_next;
    a_sh         <= a_sh_next;
    b_sh         <= b_sh_next;
    p            <= p_next;
    q            <= q_next;
    rem          <= rem_next;
    dvs          <= dvs_next;
    quo          <= quo_next;
    step         <= step_next;
    sum          <= sum_next;
    fin_div      <= fin_div_next;
    res          <= res_next;
    st           <= st_next;
    result_value <= result_next;
    status       <= status_next;
  end

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == hsc_pkg::STAT_EMPTY) |-> (result_value == 40'd0))
    else $error("empty-histogram result not zero");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == hsc_pkg::STAT_SAT) |-> (result_value == hsc_pkg::OUT_MAX))
    else $error("saturated result not all ones");

  a_peak_tracks: assert property (@(posedge clk) disable iff (rst)
    (state == hsc_pkg::S_INC_WR) |=> (peak >= $past(inc_val)))
    else $error("peak below incremented count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == hsc_pkg::S_INIT) |-> in_stall)
    else $error("transaction accepted during clearing pass");
`endif

endmodule
